@@ design/assert_macros.svh @@
// Assertion shorthands used by the checker file pidc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds at an edge -> cons holds at the following edge
`define PIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidc: next-cycle property failed");

// ante holds at an edge -> cons holds at the same edge
`define PIDC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidc: same-cycle property failed");

`endif

@@ design/pidc_pkg.sv @@
`default_nettype none

package pidc_pkg;

    localparam int DATA_W        = 32;
    localparam int PERIOD_W      = 31;
    localparam int CFG_IDX_W     = 3;
    localparam int INTEG_W       = 48;
    localparam int MUL_A_W       = 33;
    localparam int MUL_B_W       = 32;
    localparam int PROD_W        = MUL_A_W + MUL_B_W;
    localparam int KI_SPLIT      = 24;
    localparam int KI_W          = 81;
    localparam int KI_HI_W       = KI_W - KI_SPLIT;
    localparam int TERM_W        = 42;
    localparam int SUM_W         = TERM_W + 2;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic signed [PROD_W-1:0] P_MAX32 = PROD_W'(64'sh7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] P_MIN32 = ~P_MAX32;
    localparam logic signed [PROD_W-1:0] P_MAXI  = PROD_W'(64'sh7FFF_FFFF_FFFF);
    localparam logic signed [PROD_W-1:0] P_MINI  = ~P_MAXI;
    localparam logic signed [KI_W-1:0]   T_MAX   = KI_W'(64'sh100_0000_0000);
    localparam logic signed [KI_W-1:0]   T_MIN   = -T_MAX;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DER  = 8'b0000_0010,
        ST_INC  = 8'b0000_0100,
        ST_KP   = 8'b0000_1000,
        ST_KIL  = 8'b0001_0000,
        ST_KIH  = 8'b0010_0000,
        ST_KD   = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        MUL_DER = 3'd0,
        MUL_INC = 3'd1,
        MUL_KP  = 3'd2,
        MUL_KIL = 3'd3,
        MUL_KIH = 3'd4,
        MUL_KD  = 3'd5
    } mul_sel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP             = 3'd0,
        REG_KI             = 3'd1,
        REG_KD             = 3'd2,
        REG_SAMPLE_PERIOD  = 3'd3,
        REG_INVERSE_PERIOD = 3'd4,
        REG_U_MAX          = 3'd5,
        REG_U_MIN          = 3'd6,
        REG_SETPOINT       = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0]   kp;
        logic [DATA_W-1:0]   ki;
        logic [DATA_W-1:0]   kd;
        logic [PERIOD_W-1:0] sample_period;
        logic [PERIOD_W-1:0] inverse_period;
        logic [PERIOD_W-1:0] u_max;
        logic [DATA_W-1:0]   u_min;
        logic [DATA_W-1:0]   setpoint;
    } pidc_cfg_t;

    typedef struct packed {
        logic     load_err;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     take_deriv;
        logic     take_integ;
        logic     take_kp;
        logic     take_lo;
        logic     take_ki;
        logic     finish;
    } pidc_cmd_t;

    typedef struct packed {
        logic out_full;
    } pidc_status_t;

    function automatic logic signed [DATA_W-1:0] sat33_to_32(input logic signed [DATA_W:0] x);
        logic signed [DATA_W-1:0] r;
        if (x[DATA_W] != x[DATA_W-1])
            r = x[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_to_32(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] c;
        if (x > P_MAX32)
            c = P_MAX32;
        else if (x < P_MIN32)
            c = P_MIN32;
        else
            c = x;
        return c[DATA_W-1:0];
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat_to_48(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] c;
        if (x > P_MAXI)
            c = P_MAXI;
        else if (x < P_MINI)
            c = P_MINI;
        else
            c = x;
        return c[INTEG_W-1:0];
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat49_to_48(
        input logic signed [INTEG_W:0] x);
        logic signed [INTEG_W-1:0] r;
        if (x[INTEG_W] != x[INTEG_W-1])
            r = x[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
        else
            r = x[INTEG_W-1:0];
        return r;
    endfunction

    function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [KI_W-1:0] x);
        logic signed [KI_W-1:0] c;
        if (x > T_MAX)
            c = T_MAX;
        else if (x < T_MIN)
            c = T_MIN;
        else
            c = x;
        return c[TERM_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ design/pidc_regs.sv @@
`default_nettype none

module pidc_regs
    import pidc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    output pidc_cfg_t                 cfg
);

    pidc_cfg_t cfg_reg;
    pidc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_KP:             cfg_next.kp             = cfg_data;
                REG_KI:             cfg_next.ki             = cfg_data;
                REG_KD:             cfg_next.kd             = cfg_data;
                REG_SAMPLE_PERIOD:  cfg_next.sample_period  = cfg_data[PERIOD_W-1:0];
                REG_INVERSE_PERIOD: cfg_next.inverse_period = cfg_data[PERIOD_W-1:0];
                REG_U_MAX:          cfg_next.u_max          = cfg_data[PERIOD_W-1:0];
                REG_U_MIN:          cfg_next.u_min          = cfg_data;
                REG_SETPOINT:       cfg_next.setpoint       = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp             <= 32'h0001_0000;
            cfg_reg.ki             <= '0;
            cfg_reg.kd             <= '0;
            cfg_reg.sample_period  <= 31'h0001_0000;
            cfg_reg.inverse_period <= 31'h0001_0000;
            cfg_reg.u_max          <= 31'h7FFF_FFFF;
            cfg_reg.u_min          <= 32'h8000_0000;
            cfg_reg.setpoint       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ design/pidc_ctrl.sv @@
`default_nettype none

module pidc_ctrl
    import pidc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  pidc_status_t status,
    output pidc_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_DER;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_err = in_valid;
                if (in_valid)
                    state_next = ST_DER;
            end
            ST_DER:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DER;
                state_next  = ST_INC;
            end
            ST_INC:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_INC;
                cmd.take_deriv = 1'b1;
                state_next     = ST_KP;
            end
            ST_KP:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_KP;
                cmd.take_integ = 1'b1;
                state_next     = ST_KIL;
            end
            ST_KIL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KIL;
                cmd.take_kp = 1'b1;
                state_next  = ST_KIH;
            end
            ST_KIH:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KIH;
                cmd.take_lo = 1'b1;
                state_next  = ST_KD;
            end
            ST_KD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KD;
                cmd.take_ki = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                // wait while the previous result still sits in the output register
                if (!status.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ design/pidc_datapath.sv @@
`default_nettype none

module pidc_datapath
    import pidc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  pidc_cfg_t              cfg,
    input  pidc_cmd_t              cmd,
    output pidc_status_t           status,
    input  wire logic [DATA_W-1:0] measurement,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      drive,
    output logic                   saturated
);

    logic signed [DATA_W-1:0]  err_reg, err_next;
    logic signed [DATA_W-1:0]  last_error_reg, last_error_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [DATA_W-1:0]  deriv_reg, deriv_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  lo_prod_reg, lo_prod_next;
    logic signed [SUM_W-1:0]   acc_reg, acc_next;
    logic [DATA_W-1:0]         drive_reg, drive_next;
    logic                      sat_reg, sat_next;
    logic                      out_valid_reg, out_valid_next;

    logic signed [MUL_A_W-1:0] err_ext, prev_ext, mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_frac, prod_half;
    logic signed [INTEG_W-1:0] inc;
    logic signed [INTEG_W-1:0] integ_hi_part;
    logic signed [KI_W-1:0]    ki_full, ki_frac;
    logic signed [TERM_W-1:0]  term_pd, term_ki;
    logic signed [SUM_W-1:0]   total, lim_hi, lim_lo, floor_v, clip1, clip2;

    assign err_ext       = MUL_A_W'(err_reg);
    assign prev_ext      = MUL_A_W'(last_error_reg);
    assign integ_hi_part = integ_reg >>> KI_SPLIT;

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DER:
            begin
                mul_a = err_ext - prev_ext;
                mul_b = $signed({1'b0, cfg.inverse_period});
            end
            MUL_INC:
            begin
                mul_a = err_ext + prev_ext;
                mul_b = $signed({1'b0, cfg.sample_period});
            end
            MUL_KP:
            begin
                mul_a = err_ext;
                mul_b = $signed(cfg.kp);
            end
            MUL_KIL:
            begin
                mul_a = $signed({{(MUL_A_W-KI_SPLIT){1'b0}}, integ_reg[KI_SPLIT-1:0]});
                mul_b = $signed(cfg.ki);
            end
            MUL_KIH:
            begin
                mul_a = MUL_A_W'(integ_hi_part);
                mul_b = $signed(cfg.ki);
            end
            MUL_KD:
            begin
                mul_a = MUL_A_W'(deriv_reg);
                mul_b = $signed(cfg.kd);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_frac = prod_reg >>> FRAC_BITS;
    assign prod_half = prod_reg >>> (FRAC_BITS + 1);
    assign inc       = sat_to_48(prod_half);
    assign term_pd   = sat_term(KI_W'(prod_frac));

    // ki * integral from two partial products, high one weighted by 2^KI_SPLIT
    assign ki_full = $signed({prod_reg[KI_HI_W-1:0], {KI_SPLIT{1'b0}}}) + KI_W'(lo_prod_reg);
    assign ki_frac = ki_full >>> FRAC_BITS;
    assign term_ki = sat_term(ki_frac);

    // output clamp: magnitude limit, then floor
    assign total   = acc_reg + SUM_W'(term_pd);
    assign lim_hi  = $signed({{(SUM_W-PERIOD_W){1'b0}}, cfg.u_max});
    assign lim_lo  = -lim_hi;
    assign floor_v = SUM_W'($signed(cfg.u_min));
    assign clip1   = (total > lim_hi) ? lim_hi : ((total < lim_lo) ? lim_lo : total);
    assign clip2   = (clip1 < floor_v) ? floor_v : clip1;

    always_comb
    begin
        err_next        = err_reg;
        last_error_next = last_error_reg;
        integ_next      = integ_reg;
        deriv_next      = deriv_reg;
        prod_next       = prod_reg;
        lo_prod_next    = lo_prod_reg;
        acc_next        = acc_reg;
        drive_next      = drive_reg;
        sat_next        = sat_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.load_err)
            err_next = sat33_to_32((DATA_W+1)'($signed(cfg.setpoint))
                                   - (DATA_W+1)'($signed(measurement)));
        if (cmd.mul_en)
            prod_next = mul_a * mul_b;
        if (cmd.take_deriv)
            deriv_next = sat_to_32(prod_frac);
        if (cmd.take_integ)
        begin
            integ_next      = sat49_to_48((INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(inc));
            last_error_next = err_reg;
        end
        if (cmd.take_kp)
            acc_next = SUM_W'(term_pd);
        if (cmd.take_lo)
            lo_prod_next = prod_reg;
        if (cmd.take_ki)
            acc_next = acc_reg + SUM_W'(term_ki);
        if (cmd.finish)
        begin
            drive_next     = clip2[DATA_W-1:0];
            sat_next       = (clip2 != total);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            integ_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            last_error_reg <= last_error_next;
            integ_reg      <= integ_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg     <= err_next;
        deriv_reg   <= deriv_next;
        prod_reg    <= prod_next;
        lo_prod_reg <= lo_prod_next;
        acc_reg     <= acc_next;
        drive_reg   <= drive_next;
        sat_reg     <= sat_next;
    end

    assign status.out_full = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign drive           = drive_reg;
    assign saturated       = sat_reg;

endmodule

`default_nettype wire

@@ design/pid_controller_saturated_core.sv @@
// An item passes DER, INC, KP, KIL, KIH, KD and FIN before its result is valid.
// Six products share one 33x32 multiplier; no new item is taken before FIN ends.
// A finished result waits in the output register and holds the next item in FIN.
// Reset (rst_n, async, active low): registers to defaults, last error and integral to 0.
`default_nettype none

module pid_controller_saturated_core
    import pidc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] measurement
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [DATA_W-1:0]         m_axis_tdata,   // [31:0] drive
    output logic [0:0]                m_axis_tuser,   // [0] saturated
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data
);

    pidc_cfg_t    cfg;
    pidc_cmd_t    cmd;
    pidc_status_t status;

    assign cfg_ready = 1'b1;

    pidc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pidc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .measurement (s_axis_tdata),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .drive       (m_axis_tdata),
        .saturated   (m_axis_tuser[0])
    );

endmodule

`default_nettype wire

@@ design/pidc_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module pidc_checker
    import pidc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [DATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]        m_axis_tuser
);

    logic out_wait;
    logic in_take;

    assign out_wait = m_axis_tvalid && !m_axis_tready;
    assign in_take  = s_axis_tvalid && s_axis_tready;

    `PIDC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, m_axis_tvalid)
    `PIDC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_wait, $stable({m_axis_tuser, m_axis_tdata}))
    `PIDC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_take, !s_axis_tready)
    `PIDC_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_take, !$rose(m_axis_tvalid))
    `PIDC_ASSERT_SAME(a_idle_on_result, clk, rst_n, $rose(m_axis_tvalid), s_axis_tready)

endmodule

bind pid_controller_saturated_core pidc_checker u_pidc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ bench/pid_drive_checker.sv @@
`default_nettype none

module pid_drive_checker
    import pidc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    input  wire logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] measurement
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic [DATA_W-1:0]    m_axis_tdata,   // [31:0] drive
    input  wire logic [0:0]           m_axis_tuser,   // [0] saturated
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    output int                        fail_count,
    output int                        pending,
    output int                        drive_count,
    output int                        clamp_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint I32_HI   = 64'sd2147483647;
    localparam longint I32_LO   = -64'sd2147483648;
    localparam longint INTEG_HI = 64'sd140737488355327;
    localparam longint INTEG_LO = -64'sd140737488355328;
    localparam longint TERM_LIM = 64'sd1099511627776;

    typedef struct packed {
        logic [DATA_W-1:0] drive;
        logic              saturated;
    } drive_item_t;

    pidc_cfg_t   settings;
    int          held_error;
    longint      integ_acc;
    drive_item_t drive_queue[$];

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // exact product, floor shift, then saturate
    function automatic longint scaled_product(input longint a, input longint b,
                                              input int sh, input longint lo,
                                              input longint hi);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] p;
        wa = a;
        wb = b;
        p = (wa * wb) >>> sh;
        if (p > hi)
            return hi;
        if (p < lo)
            return lo;
        return p[63:0];
    endfunction

    function automatic drive_item_t predict_drive(input logic [DATA_W-1:0] meas);
        drive_item_t r;
        longint err;
        longint prev;
        longint deriv;
        longint inc;
        longint u;
        longint res;
        longint umax;
        longint umin;
        err = clip(longint'($signed(settings.setpoint)) - longint'($signed(meas)),
                   I32_LO, I32_HI);
        prev = held_error;
        umax = longint'(settings.u_max);
        umin = longint'($signed(settings.u_min));
        deriv = scaled_product(err - prev, longint'(settings.inverse_period),
                               FRAC_BITS_DEF, I32_LO, I32_HI);
        inc = scaled_product(err + prev, longint'(settings.sample_period),
                             FRAC_BITS_DEF + 1, INTEG_LO, INTEG_HI);
        integ_acc = clip(integ_acc + inc, INTEG_LO, INTEG_HI);
        held_error = int'(err);
        u = scaled_product(err, longint'($signed(settings.kp)), FRAC_BITS_DEF,
                           -TERM_LIM, TERM_LIM)
          + scaled_product(integ_acc, longint'($signed(settings.ki)), FRAC_BITS_DEF,
                           -TERM_LIM, TERM_LIM)
          + scaled_product(deriv, longint'($signed(settings.kd)), FRAC_BITS_DEF,
                           -TERM_LIM, TERM_LIM);
        res = u;
        if (res > umax)
            res = umax;
        else if (res < -umax)
            res = -umax;
        if (res < umin)
            res = umin;
        r.drive = res[DATA_W-1:0];
        r.saturated = (res != u);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_item_t want;
        if (!rst_n)
        begin
            settings.kp             = 32'h0001_0000;
            settings.ki             = '0;
            settings.kd             = '0;
            settings.sample_period  = 31'h0001_0000;
            settings.inverse_period = 31'h0001_0000;
            settings.u_max          = 31'h7FFF_FFFF;
            settings.u_min          = 32'h8000_0000;
            settings.setpoint       = '0;
            held_error  = 0;
            integ_acc   = 0;
            drive_queue.delete();
            fail_count  = 0;
            drive_count = 0;
            clamp_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_KP:             settings.kp = cfg_data;
                    REG_KI:             settings.ki = cfg_data;
                    REG_KD:             settings.kd = cfg_data;
                    REG_SAMPLE_PERIOD:  settings.sample_period = cfg_data[PERIOD_W-1:0];
                    REG_INVERSE_PERIOD: settings.inverse_period = cfg_data[PERIOD_W-1:0];
                    REG_U_MAX:          settings.u_max = cfg_data[PERIOD_W-1:0];
                    REG_U_MIN:          settings.u_min = cfg_data;
                    REG_SETPOINT:       settings.setpoint = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                drive_queue.push_back(predict_drive(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (drive_queue.size() == 0)
                begin
                    $error("unexpected drive item %0d", $signed(m_axis_tdata));
                    fail_count++;
                end
                else
                begin
                    want = drive_queue.pop_front();
                    drive_count++;
                    if (m_axis_tuser[0])
                        clamp_count++;
                    if (m_axis_tdata !== want.drive)
                    begin
                        $error("drive mismatch: expected %0d, got %0d",
                               $signed(want.drive), $signed(m_axis_tdata));
                        fail_count++;
                    end
                    if (m_axis_tuser[0] !== want.saturated)
                    begin
                        $error("saturated mismatch: expected %0b, got %0b",
                               want.saturated, m_axis_tuser[0]);
                        fail_count++;
                    end
                end
            end
        end
        pending = drive_queue.size();
    end

endmodule

`default_nettype wire

@@ bench/pid_controller_saturated_core_test.sv @@
`default_nettype none

module pid_controller_saturated_core_test
    import pidc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 5000;
    localparam int SEGMENTS     = 8;
    localparam int SEG_SAMPLES  = 230;
    localparam int TAIL_CYCLES  = 20;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DATA_W-1:0]    m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    int fail_count;
    int pending;
    int drive_count;
    int clamp_count;

    int        idle_pct = 0;
    int        stall_pct = 0;
    int        samples_sent = 0;
    int        settings_applied = 0;
    int        quiet_cycles = 0;
    pidc_cfg_t active;

    pid_controller_saturated_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pid_drive_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .drive_count   (drive_count),
        .clamp_count   (clamp_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic pidc_cfg_t settings(input logic [31:0] kp, input logic [31:0] ki,
                                           input logic [31:0] kd, input logic [30:0] sp,
                                           input logic [30:0] ip, input logic [30:0] umax,
                                           input logic [31:0] umin, input logic [31:0] setp);
        pidc_cfg_t c;
        c.kp = kp;
        c.ki = ki;
        c.kd = kd;
        c.sample_period = sp;
        c.inverse_period = ip;
        c.u_max = umax;
        c.u_min = umin;
        c.setpoint = setp;
        return c;
    endfunction

    function automatic logic [31:0] random_gain();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3, 4, 5, 6: return $urandom_range(32'h8_0000) - 32'h4_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] random_period();
        case ($urandom_range(9))
            0: return 31'h0;
            1: return 31'h7FFF_FFFF;
            2, 3, 4, 5, 6: return 31'($urandom_range(32'h2_0000, 1));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] extreme_value();
        return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    function automatic pidc_cfg_t random_settings();
        pidc_cfg_t c;
        c.kp = random_gain();
        c.ki = random_gain();
        c.kd = random_gain();
        c.sample_period = random_period();
        c.inverse_period = random_period();
        case ($urandom_range(9))
            0: c.u_max = 31'h0;
            1, 2, 3: c.u_max = 31'h7FFF_FFFF;
            4, 5, 6: c.u_max = 31'($urandom_range(32'h100_0000));
            default: c.u_max = 31'($urandom);
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3: c.u_min = 32'h8000_0000;
            4: c.u_min = 32'h7FFF_FFFF;
            5, 6: c.u_min = -$urandom_range(32'h100_0000);
            default: c.u_min = $urandom;
        endcase
        case ($urandom_range(3))
            0: c.setpoint = $urandom;
            1: c.setpoint = extreme_value();
            default: c.setpoint = $urandom_range(32'h8_0000) - 32'h4_0000;
        endcase
        return c;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic apply_settings(input pidc_cfg_t c);
        write_reg(REG_KP, c.kp);
        write_reg(REG_KI, c.ki);
        write_reg(REG_KD, c.kd);
        write_reg(REG_SAMPLE_PERIOD, {1'($urandom_range(1)), c.sample_period});
        write_reg(REG_INVERSE_PERIOD, {1'($urandom_range(1)), c.inverse_period});
        write_reg(REG_U_MAX, {1'($urandom_range(1)), c.u_max});
        write_reg(REG_U_MIN, c.u_min);
        write_reg(REG_SETPOINT, c.setpoint);
        cfg_valid <= 1'b0;
        active = c;
        settings_applied++;
    endtask

    task automatic send_sample(input logic [31:0] meas);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= meas;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        samples_sent++;
    endtask

    task automatic wait_for_drives();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    function automatic logic [31:0] random_measurement();
        case ($urandom_range(9))
            0:
                case ($urandom_range(2))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    default: return 32'h0;
                endcase
            1, 2, 3, 4, 5, 6:
                return active.setpoint + $urandom_range(32'h8_0000) - 32'h4_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_checked(input logic [31:0] meas);
        send_sample(meas);
        wait_for_drives();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, extremes of the measurement, error saturation
        active = settings(32'h1_0000, 32'h0, 32'h0, 31'h1_0000, 31'h1_0000,
                          31'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_checked(32'h0);
        send_checked(32'h7FFF_FFFF);
        send_checked(32'h8000_0000);
        send_checked(32'h0000_0001);
        send_checked(32'hFFFF_FFFF);

        // extreme gains and periods: derivative, integral and term overflow
        apply_settings(settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                                31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000,
                                32'h7FFF_FFFF));
        send_checked(32'h8000_0000);
        send_checked(32'h8000_0000);
        send_checked(32'h8000_0000);
        send_checked(32'h7FFF_FFFF);
        send_checked(32'h0);
        send_checked(32'h8000_0000);

        // floor above the magnitude limit
        apply_settings(settings(32'h1_0000, 32'h0, 32'h0, 31'h1_0000, 31'h1_0000,
                                31'h1_0000, 32'h2_0000, 32'h0));
        send_checked(32'h7FFF_FFFF);
        send_checked(32'h8000_0000);
        send_checked(32'h0);

        // zero limit, minimum setpoint
        apply_settings(settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0, 31'h0,
                                31'h0, 32'h8000_0000, 32'h8000_0000));
        send_checked(32'h7FFF_FFFF);
        send_checked(32'h1234_5678);
        send_checked(32'h8000_0000);

        // maximum floor
        apply_settings(settings(32'h1_0000, 32'h1_0000, 32'h1_0000, 31'h8000, 31'h2_0000,
                                31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
        send_checked(32'h0000_0001);
        send_checked(32'hFFFF_0000);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_for_drives();
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            apply_settings(random_settings());
            for (int n = 0; n < SEG_SAMPLES; n++)
                send_sample(random_measurement());
        end

        wait_for_drives();
        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d samples under %0d register settings with four idle patterns;",
                 samples_sent, settings_applied);
        $display("checked %0d drive items, %0d of them clamped.", drive_count, clamp_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ pid_controller_saturated_core.f @@
+incdir+design
design/pidc_pkg.sv
design/pidc_regs.sv
design/pidc_ctrl.sv
design/pidc_datapath.sv
design/pid_controller_saturated_core.sv
design/pidc_checker.sv
bench/pid_drive_checker.sv
bench/pid_controller_saturated_core_test.sv
